[sv/rpi_pkg.sv]
// Shared types, widths and constants of the radial profile interpolator.
// Used by the interfaces, the arithmetic unit and the core; no dependencies.
`default_nettype none
package rpi_pkg;

  localparam int unsigned DATA_W  = 48;   // Q16.32 values
  localparam int unsigned PRES_W  = 64;   // Q16.48 pressure
  localparam int unsigned PROD_W  = 97;   // sum of two 48x48 products
  localparam int unsigned DEN_W   = 49;   // distance sum / multiplicand
  localparam int unsigned REM_W   = 50;   // divider partial remainder
  localparam int unsigned CNT_W   = 7;    // step counter of the shared unit
  localparam int unsigned TLEN_W  = 11;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ROW_BITS  = 3 * DATA_W;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_FACTOR = 2'd1;

  localparam logic [TLEN_W-1:0] TLEN_RST = 11'd1024;
  localparam logic [DATA_W-1:0] PFAC_RST = 48'd2814750;

  localparam logic [DATA_W-1:0] SIGN48   = 48'h8000_0000_0000;
  localparam logic [DATA_W-1:0] MAX48    = 48'hFFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] INV_SAT_R = 48'h0001_0000_0000 >> 8; // 2^24

  localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd48;
  localparam logic [CNT_W-1:0] IDIV_STEPS = 7'd48;
  localparam logic [CNT_W-1:0] FDIV_STEPS = 7'd97;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic {ALU_MUL, ALU_DIV} alu_op_e;

  typedef struct packed {
    alu_op_e                op;
    logic [PROD_W-1:0]      num;   // shift register: multiplier or dividend bits
    logic [REM_W-1:0]       rem;   // initial remainder (divide)
    logic [DEN_W-1:0]       den;   // divisor or multiplicand
    logic [CNT_W-1:0]       cnt;   // number of steps
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] res;
  } alu_rsp_t;

endpackage
`default_nettype wire

[sv/rpi_intf.sv]
// Channel interfaces of the radial profile interpolator: request, result
// and configuration write. Depends on rpi_pkg.
`default_nettype none
interface rpi_req_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [rpi_pkg::ROW_W-1:0]        row_index;
  logic [rpi_pkg::DATA_W-1:0]       radius;
  logic [rpi_pkg::DATA_W-1:0]       row_density;
  logic signed [rpi_pkg::DATA_W-1:0] row_velocity;
  modport source (output valid, command, row_index, radius, row_density, row_velocity,
                  input ready);
  modport sink   (input valid, command, row_index, radius, row_density, row_velocity,
                  output ready);
endinterface

interface rpi_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rpi_pkg::DATA_W-1:0]       density;
  logic [rpi_pkg::PRES_W-1:0]       pressure;
  logic signed [rpi_pkg::DATA_W-1:0] velocity;
  logic                             inner_material;
  logic                             beyond_table;
  modport source (output valid, density, pressure, velocity, inner_material, beyond_table,
                  input ready);
  modport sink   (input valid, density, pressure, velocity, inner_material, beyond_table,
                  output ready);
endinterface

interface rpi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpi_pkg::CFG_IDX_W-1:0]  index;
  logic [rpi_pkg::DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/rpi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rpi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[sv/rpi_alu.sv]
// Shared shift-add multiplier / restoring divider, one bit per cycle.
// Depends on rpi_pkg for widths and the request/response structs.
`default_nettype none
module rpi_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire rpi_pkg::alu_req_t req_i,
  output rpi_pkg::alu_rsp_t      rsp_o
);

  logic                          busy_q, busy_d, done_q, done_d;
  logic [rpi_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  rpi_pkg::alu_op_e              op_q, op_d;
  logic [rpi_pkg::PROD_W-1:0]    num_q, num_d, acc_q, acc_d;
  logic [rpi_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [rpi_pkg::DEN_W-1:0]     den_q, den_d;

  logic                          lead;
  logic [rpi_pkg::REM_W-1:0]     shifted;
  logic                          fits;

  // one step of either operation
  assign lead    = num_q[rpi_pkg::PROD_W-1];
  assign shifted = {rem_q[rpi_pkg::REM_W-2:0], lead};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    num_d  = num_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.cnt;
      op_d   = req_i.op;
      num_d  = req_i.num;
      rem_d  = req_i.rem;
      den_d  = req_i.den;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (op_q == rpi_pkg::ALU_MUL) begin
        acc_d = {acc_q[rpi_pkg::PROD_W-2:0], 1'b0}
              + (lead ? rpi_pkg::PROD_W'(den_q) : '0);
        num_d = {num_q[rpi_pkg::PROD_W-2:0], 1'b0};
      end else begin
        rem_d = fits ? shifted - {1'b0, den_q} : shifted;
        num_d = {num_q[rpi_pkg::PROD_W-2:0], fits};
      end
      if (cnt_q == rpi_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    num_q <= num_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == rpi_pkg::ALU_MUL) ? acc_q : num_q;

endmodule
`default_nettype wire

[sv/radial_profile_interpolator_core.sv]
// Radial profile interpolator top level: row table, scan sequencer, result.
// Depends on rpi_pkg, rpi_intf, rpi_ram and rpi_alu.
//
// Use: req_i carries load requests (command 0: write radius, density and
// velocity of one row) and queries (command 1: radius to look up). A load
// gives no result. A query scans the table one row a cycle through the
// registered RAM read port, then drives a shared bit-serial multiply/divide
// unit for the interpolation weights, the inverse square beyond the table
// and the pressure product. The multiplies and the interpolation divides
// run 48 steps and the divides beyond the table 97; beyond the table, a
// radius of at most 2^-8 skips both divides and saturates the density.
// req_i.ready is low while a query is in work.
// Results sit in an output register on rsp_o; a stalled receiver holds
// the next finished query but loads are still taken. cfg_i is always
// ready and must only be written while idle. Reset clears control state
// and restores the registers; table contents are undefined until loaded.
`default_nettype none
module radial_profile_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = rpi_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rpi_req_if.sink    req_i,
  rpi_rsp_if.source  rsp_o,
  rpi_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (AW + 1 > rpi_pkg::TLEN_W) ? AW + 1 : rpi_pkg::TLEN_W;
  localparam int unsigned WW = ((rpi_pkg::ROW_W > AW) ? rpi_pkg::ROW_W : AW) + 1;
  localparam int unsigned DW = rpi_pkg::DATA_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_RDLO = 4'd2;
  localparam logic [3:0] S_RDHI = 4'd3;
  localparam logic [3:0] S_DIST = 4'd4;
  localparam logic [3:0] S_DM1  = 4'd5;
  localparam logic [3:0] S_DM2  = 4'd6;
  localparam logic [3:0] S_DDV  = 4'd7;
  localparam logic [3:0] S_VM1  = 4'd8;
  localparam logic [3:0] S_VM2  = 4'd9;
  localparam logic [3:0] S_VDV  = 4'd10;
  localparam logic [3:0] S_INV1 = 4'd11;
  localparam logic [3:0] S_INV2 = 4'd12;
  localparam logic [3:0] S_PMUL = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]                 state_q, state_d;
  logic [AW-1:0]              k_q, k_d, l_q, l_d;
  logic                       issued_q, issued_d;
  logic                       beyond_q, beyond_d;
  logic [rpi_pkg::TLEN_W-1:0] tlen_q;
  logic [DW-1:0]              pfac_q;
  logic                       ovalid_q, ovalid_d;

  logic [DW-1:0]              r_q, r_d, rlo_q, rlo_d;
  logic [DW-1:0]              rho_lo_q, rho_lo_d, rho_hi_q, rho_hi_d;
  logic [DW-1:0]              v_lo_q, v_lo_d, v_hi_q, v_hi_d;
  logic [DW-1:0]              dm_q, dm_d, dp_q, dp_d;
  logic [rpi_pkg::DEN_W-1:0]  den_q, den_d;
  logic [rpi_pkg::PROD_W-1:0] p1_q, p1_d, sum_q, sum_d;
  logic [DW-1:0]              dens_q, dens_d, vel_q, vel_d;

  logic [DW-1:0]              o_dens_q, o_vel_q;
  logic [rpi_pkg::PRES_W-1:0] o_pres_q, pres;
  logic                       o_beyond_q;

  logic [CW-1:0]              tlen_ext, n_c;
  logic [AW-1:0]              n_m2;
  logic [AW-1:0]              raddr, waddr;
  logic                       we;
  logic [WW-1:0]              row_ext;
  logic [rpi_pkg::ROW_BITS-1:0] wdata, rdata;
  logic [DW-1:0]              rd_rad, rd_rho, rd_vel;
  logic                       req_fire, stop, is_op, out_free, skip_div;
  logic [AW-1:0]              l_scan;

  rpi_pkg::alu_req_t          alu_req;
  rpi_pkg::alu_rsp_t          alu_rsp;
  logic                       alu_start;

  // effective table length, clamped to [2, TABLE_DEPTH]
  always_comb begin
    tlen_ext = CW'(tlen_q);
    if (tlen_ext < CW'(2)) begin
      n_c = CW'(2);
    end else if (tlen_ext > CW'(TABLE_DEPTH)) begin
      n_c = CW'(TABLE_DEPTH);
    end else begin
      n_c = tlen_ext;
    end
  end
  assign n_m2 = AW'(n_c - CW'(2));

  // configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q <= rpi_pkg::TLEN_RST;
      pfac_q <= rpi_pkg::PFAC_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rpi_pkg::CFG_TABLE_LENGTH:    tlen_q <= cfg_i.data[rpi_pkg::TLEN_W-1:0];
        rpi_pkg::CFG_PRESSURE_FACTOR: pfac_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // row table
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign row_ext     = WW'(req_i.row_index);
  assign we          = req_fire && (req_i.command == rpi_pkg::CMD_LOAD)
                     && (row_ext < WW'(TABLE_DEPTH));
  assign waddr       = AW'(req_i.row_index);
  assign wdata       = {req_i.radius, req_i.row_density, req_i.row_velocity};

  always_comb begin
    unique case (state_q)
      S_SCAN:  raddr = k_q + AW'(1);
      S_RDLO:  raddr = l_q - AW'(1);
      S_RDHI:  raddr = l_q;
      default: raddr = '0;
    endcase
  end

  rpi_ram #(
    .WIDTH (rpi_pkg::ROW_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_rad = rdata[3*DW-1:2*DW];
  assign rd_rho = rdata[2*DW-1:DW];
  assign rd_vel = rdata[DW-1:0];

  // scan stop and index floor
  assign stop   = (k_q == n_m2) || !(rd_rad < r_q);
  assign l_scan = (k_q == '0) ? AW'(1) : k_q;

  // operand selection for the shared unit
  assign is_op = (state_q == S_DM1) || (state_q == S_DM2) || (state_q == S_DDV)
              || (state_q == S_VM1) || (state_q == S_VM2) || (state_q == S_VDV)
              || (state_q == S_INV1) || (state_q == S_INV2) || (state_q == S_PMUL);

  always_comb begin
    alu_req.op  = rpi_pkg::ALU_MUL;
    alu_req.num = '0;
    alu_req.rem = '0;
    alu_req.den = '0;
    alu_req.cnt = rpi_pkg::MUL_STEPS;
    unique case (state_q) inside
      S_DM1: begin
        alu_req.num = {dp_q, 49'd0};
        alu_req.den = rpi_pkg::DEN_W'(rho_lo_q);
      end
      S_DM2: begin
        alu_req.num = {dm_q, 49'd0};
        alu_req.den = rpi_pkg::DEN_W'(rho_hi_q);
      end
      S_VM1: begin
        alu_req.num = {dp_q, 49'd0};
        alu_req.den = rpi_pkg::DEN_W'(v_lo_q ^ rpi_pkg::SIGN48);
      end
      S_VM2: begin
        alu_req.num = {dm_q, 49'd0};
        alu_req.den = rpi_pkg::DEN_W'(v_hi_q ^ rpi_pkg::SIGN48);
      end
      S_DDV, S_VDV: begin
        alu_req.op  = rpi_pkg::ALU_DIV;
        alu_req.num = {sum_q[DW-1:0], 49'd0};
        alu_req.rem = rpi_pkg::REM_W'(sum_q[rpi_pkg::PROD_W-1:DW]);
        alu_req.den = den_q;
        alu_req.cnt = rpi_pkg::IDIV_STEPS;
      end
      S_INV1: begin
        alu_req.op  = rpi_pkg::ALU_DIV;
        alu_req.num = {1'b1, 96'd0};
        alu_req.den = rpi_pkg::DEN_W'(r_q);
        alu_req.cnt = rpi_pkg::FDIV_STEPS;
      end
      S_INV2: begin
        alu_req.op  = rpi_pkg::ALU_DIV;
        alu_req.num = sum_q;
        alu_req.den = rpi_pkg::DEN_W'(r_q);
        alu_req.cnt = rpi_pkg::FDIV_STEPS;
      end
      S_PMUL: begin
        alu_req.num = {pfac_q, 49'd0};
        alu_req.den = rpi_pkg::DEN_W'(dens_q);
      end
      default: ;
    endcase
  end

  // a zero distance sum takes the lower row without a divide
  assign skip_div  = ((state_q == S_DDV) || (state_q == S_VDV)) && (den_q == '0);
  assign alu_start = is_op && !skip_div && !issued_q && !alu_rsp.busy;

  rpi_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .req_i   (alu_req),
    .rsp_o   (alu_rsp)
  );

  // saturating pressure from the stored product
  assign pres = (|p1_q[95:80]) ? '1 : p1_q[79:16];
  assign out_free = !ovalid_q || rsp_o.ready;

  // sequencer
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    l_d      = l_q;
    issued_d = issued_q;
    beyond_d = beyond_q;
    r_d      = r_q;
    rlo_d    = rlo_q;
    rho_lo_d = rho_lo_q;
    rho_hi_d = rho_hi_q;
    v_lo_d   = v_lo_q;
    v_hi_d   = v_hi_q;
    dm_d     = dm_q;
    dp_d     = dp_q;
    den_d    = den_q;
    p1_d     = p1_q;
    sum_d    = sum_q;
    dens_d   = dens_q;
    vel_d    = vel_q;
    ovalid_d = ovalid_q && !rsp_o.ready;
    if (alu_start) begin
      issued_d = 1'b1;
    end
    if (alu_rsp.done) begin
      issued_d = 1'b0;
    end
    unique case (state_q) inside
      S_IDLE: begin
        if (req_fire && req_i.command == rpi_pkg::CMD_QUERY) begin
          r_d     = req_i.radius;
          k_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stop) begin
          l_d      = l_scan;
          beyond_d = (l_scan == n_m2);
          if (l_scan == n_m2) begin
            vel_d = '0;
            if (r_q <= rpi_pkg::INV_SAT_R) begin
              dens_d  = rpi_pkg::MAX48;
              state_d = S_PMUL;
            end else begin
              state_d = S_INV1;
            end
          end else begin
            state_d = S_RDLO;
          end
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      S_RDLO: state_d = S_RDHI;
      S_RDHI: begin
        rlo_d    = rd_rad;
        rho_lo_d = rd_rho;
        v_lo_d   = rd_vel;
        state_d  = S_DIST;
      end
      S_DIST: begin
        rho_hi_d = rd_rho;
        v_hi_d   = rd_vel;
        dm_d     = (r_q >= rlo_q) ? r_q - rlo_q : rlo_q - r_q;
        dp_d     = (rd_rad >= r_q) ? rd_rad - r_q : r_q - rd_rad;
        den_d    = rpi_pkg::DEN_W'(dm_d) + rpi_pkg::DEN_W'(dp_d);
        state_d  = S_DM1;
      end
      S_DM1, S_VM1: begin
        if (alu_rsp.done) begin
          p1_d    = alu_rsp.res;
          state_d = (state_q == S_DM1) ? S_DM2 : S_VM2;
        end
      end
      S_DM2, S_VM2: begin
        if (alu_rsp.done) begin
          sum_d   = p1_q + alu_rsp.res;
          state_d = (state_q == S_DM2) ? S_DDV : S_VDV;
        end
      end
      S_DDV: begin
        if (den_q == '0) begin
          dens_d   = rho_lo_q;
          issued_d = 1'b0;
          state_d  = S_VM1;
        end else if (alu_rsp.done) begin
          dens_d  = alu_rsp.res[DW-1:0];
          state_d = S_VM1;
        end
      end
      S_VDV: begin
        if (den_q == '0) begin
          vel_d    = v_lo_q;
          issued_d = 1'b0;
          state_d  = S_PMUL;
        end else if (alu_rsp.done) begin
          vel_d   = alu_rsp.res[DW-1:0] ^ rpi_pkg::SIGN48;
          state_d = S_PMUL;
        end
      end
      S_INV1: begin
        if (alu_rsp.done) begin
          sum_d   = alu_rsp.res;
          state_d = S_INV2;
        end
      end
      S_INV2: begin
        if (alu_rsp.done) begin
          dens_d  = (|alu_rsp.res[rpi_pkg::PROD_W-1:DW]) ? rpi_pkg::MAX48
                                                         : alu_rsp.res[DW-1:0];
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        if (alu_rsp.done) begin
          p1_d    = alu_rsp.res;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
      l_q      <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      l_q      <= l_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    beyond_q <= beyond_d;
    r_q      <= r_d;
    rlo_q    <= rlo_d;
    rho_lo_q <= rho_lo_d;
    rho_hi_q <= rho_hi_d;
    v_lo_q   <= v_lo_d;
    v_hi_q   <= v_hi_d;
    dm_q     <= dm_d;
    dp_q     <= dp_d;
    den_q    <= den_d;
    p1_q     <= p1_d;
    sum_q    <= sum_d;
    dens_q   <= dens_d;
    vel_q    <= vel_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      o_dens_q   <= dens_q;
      o_vel_q    <= vel_q;
      o_pres_q   <= pres;
      o_beyond_q <= beyond_q;
    end
  end

  assign rsp_o.valid          = ovalid_q;
  assign rsp_o.density        = o_dens_q;
  assign rsp_o.pressure       = o_pres_q;
  assign rsp_o.velocity       = o_vel_q;
  assign rsp_o.inner_material = !o_beyond_q;
  assign rsp_o.beyond_table   = o_beyond_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (k_q <= n_m2))
    else $error("scan index past outer limit");
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.command == rpi_pkg::CMD_QUERY) |=> !req_i.ready)
    else $error("request taken during a query");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !rsp_o.ready) |=> (ovalid_q && $stable(o_dens_q)))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
